FILE: sv/wsfr_pkg.sv
// Shared types and constants for the frame receiver.
`timescale 1ns / 1ps

package wsfr_pkg;

    // Record types
    localparam logic [1:0] REC_START   = 2'd0;
    localparam logic [1:0] REC_PAYLOAD = 2'd1;
    localparam logic [1:0] REC_CLOSE   = 2'd2;
    localparam logic [1:0] REC_ERROR   = 2'd3;

    // Frame kinds
    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_BINARY = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_PING   = 3'd3;
    localparam logic [2:0] KIND_PONG   = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_RSV        = 3'd0;
    localparam logic [2:0] ERR_UNMASKED   = 3'd1;
    localparam logic [2:0] ERR_CONT       = 3'd2;
    localparam logic [2:0] ERR_FRAG_CTRL  = 3'd3;
    localparam logic [2:0] ERR_CTRL_LONG  = 3'd4;
    localparam logic [2:0] ERR_BAD_OPCODE = 3'd5;

    // Opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Commands
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Length byte codes and control frame limit
    localparam logic [6:0]  LEN_EXT16   = 7'd126;
    localparam logic [6:0]  LEN_EXT64   = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

    typedef struct packed {
        logic [1:0]  rec_type;
        logic [2:0]  kind;
        logic [63:0] length;
        logic [7:0]  data;
        logic [15:0] reason;
        logic [2:0]  err;
        logic        last;
    } rec_t;

endpackage

FILE: sv/wsfr_parser.sv
// Front end: byte-wise frame header parser, unmasking and record builder.
`timescale 1ns / 1ps

module wsfr_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               command,
    input  logic [7:0]         data_byte,
    output logic               rec_valid,
    output wsfr_pkg::rec_t     rec
);

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_EXT   = 3'd2;
    localparam logic [2:0] PH_KEY   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CLOSE = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic [63:0] remain_reg, remain_next;
    logic [15:0] reason_reg, reason_next;
    logic [1:0]  close_cnt_reg, close_cnt_next;
    logic        halted_reg, halted_next;
    logic        fault_valid_reg, fault_valid_next;
    logic [2:0]  fault_code_reg, fault_code_next;

    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic        hdr_err;
    logic [2:0]  hdr_err_code;
    logic [2:0]  hdr_kind;
    logic [2:0]  data_kind;

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        plain = data_byte ^ key_byte;
    end

    // Header verdict; first fault latched in the header wins
    always_comb
    begin
        hdr_err      = 1'b1;
        hdr_err_code = wsfr_pkg::ERR_RSV;
        if (fault_valid_reg)
            hdr_err_code = fault_code_reg;
        else if (opcode_reg == wsfr_pkg::OP_CONT)
            hdr_err_code = wsfr_pkg::ERR_CONT;
        else if (opcode_reg == wsfr_pkg::OP_TEXT || opcode_reg == wsfr_pkg::OP_BINARY)
            hdr_err = 1'b0;
        else if (!fin_reg)
            hdr_err_code = wsfr_pkg::ERR_FRAG_CTRL;
        else if (len_acc_reg > wsfr_pkg::CTRL_MAX_LEN)
            hdr_err_code = wsfr_pkg::ERR_CTRL_LONG;
        else if (opcode_reg != wsfr_pkg::OP_CLOSE && opcode_reg != wsfr_pkg::OP_PING
                 && opcode_reg != wsfr_pkg::OP_PONG)
            hdr_err_code = wsfr_pkg::ERR_BAD_OPCODE;
        else
            hdr_err = 1'b0;
    end

    always_comb
    begin
        case (opcode_reg)
            wsfr_pkg::OP_TEXT:   hdr_kind = wsfr_pkg::KIND_TEXT;
            wsfr_pkg::OP_BINARY: hdr_kind = wsfr_pkg::KIND_BINARY;
            wsfr_pkg::OP_CLOSE:  hdr_kind = wsfr_pkg::KIND_CLOSE;
            wsfr_pkg::OP_PING:   hdr_kind = wsfr_pkg::KIND_PING;
            default:             hdr_kind = wsfr_pkg::KIND_PONG;
        endcase
        case (opcode_reg)
            wsfr_pkg::OP_TEXT:   data_kind = wsfr_pkg::KIND_TEXT;
            wsfr_pkg::OP_BINARY: data_kind = wsfr_pkg::KIND_BINARY;
            wsfr_pkg::OP_PING:   data_kind = wsfr_pkg::KIND_PING;
            default:             data_kind = wsfr_pkg::KIND_PONG;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        opcode_next      = opcode_reg;
        fin_next         = fin_reg;
        len_acc_next     = len_acc_reg;
        ext_left_next    = ext_left_reg;
        key_next         = key_reg;
        idx_next         = idx_reg;
        remain_next      = remain_reg;
        reason_next      = reason_reg;
        close_cnt_next   = close_cnt_reg;
        halted_next      = halted_reg;
        fault_valid_next = fault_valid_reg;
        fault_code_next  = fault_code_reg;
        rec_valid        = 1'b0;
        rec              = '0;

        if (accept && command == wsfr_pkg::CMD_RESTART)
        begin
            phase_next       = PH_LEAD;
            opcode_next      = '0;
            fin_next         = 1'b0;
            len_acc_next     = '0;
            ext_left_next    = '0;
            key_next         = '0;
            idx_next         = '0;
            remain_next      = '0;
            reason_next      = '0;
            close_cnt_next   = '0;
            halted_next      = 1'b0;
            fault_valid_next = 1'b0;
            fault_code_next  = '0;
        end
        else if (accept && !halted_reg)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (!data_byte[7] && !fault_valid_reg)
                    begin
                        fault_valid_next = 1'b1;
                        fault_code_next  = wsfr_pkg::ERR_UNMASKED;
                    end
                    idx_next = '0;
                    key_next = '0;
                    if (data_byte[6:0] == wsfr_pkg::LEN_EXT16)
                    begin
                        len_acc_next  = '0;
                        ext_left_next = 4'd2;
                        phase_next    = PH_EXT;
                    end
                    else if (data_byte[6:0] == wsfr_pkg::LEN_EXT64)
                    begin
                        len_acc_next  = '0;
                        ext_left_next = 4'd8;
                        phase_next    = PH_EXT;
                    end
                    else
                    begin
                        len_acc_next = {57'd0, data_byte[6:0]};
                        phase_next   = PH_KEY;
                    end
                end
                PH_EXT:
                begin
                    len_acc_next  = {len_acc_reg[55:0], data_byte};
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_reg == 4'd1)
                        phase_next = PH_KEY;
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], data_byte};
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        rec_valid = 1'b1;
                        if (hdr_err)
                        begin
                            rec.rec_type = wsfr_pkg::REC_ERROR;
                            rec.err      = hdr_err_code;
                            rec.last     = 1'b1;
                            halted_next  = 1'b1;
                        end
                        else
                        begin
                            remain_next    = len_acc_reg;
                            reason_next    = '0;
                            close_cnt_next = '0;
                            if (opcode_reg == wsfr_pkg::OP_CLOSE)
                            begin
                                if (len_acc_reg == 64'd0)
                                begin
                                    rec.rec_type = wsfr_pkg::REC_CLOSE;
                                    rec.kind     = wsfr_pkg::KIND_CLOSE;
                                    rec.last     = 1'b1;
                                    phase_next   = PH_LEAD;
                                end
                                else
                                begin
                                    rec_valid  = 1'b0;
                                    phase_next = PH_CLOSE;
                                end
                            end
                            else
                            begin
                                rec.rec_type = wsfr_pkg::REC_START;
                                rec.kind     = hdr_kind;
                                rec.length   = len_acc_reg;
                                rec.last     = (len_acc_reg == 64'd0);
                                phase_next   = (len_acc_reg == 64'd0) ? PH_LEAD : PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    idx_next     = idx_reg + 2'd1;
                    remain_next  = remain_reg - 64'd1;
                    rec_valid    = 1'b1;
                    rec.rec_type = wsfr_pkg::REC_PAYLOAD;
                    rec.kind     = data_kind;
                    rec.data     = plain;
                    rec.last     = (remain_reg == 64'd1);
                    if (remain_reg == 64'd1)
                        phase_next = PH_LEAD;
                end
                PH_CLOSE:
                begin
                    if (close_cnt_reg != 2'd2)
                    begin
                        reason_next    = {reason_reg[7:0], plain};
                        close_cnt_next = close_cnt_reg + 2'd1;
                    end
                    idx_next    = idx_reg + 2'd1;
                    remain_next = remain_reg - 64'd1;
                    if (remain_reg == 64'd1)
                    begin
                        rec_valid    = 1'b1;
                        rec.rec_type = wsfr_pkg::REC_CLOSE;
                        rec.kind     = wsfr_pkg::KIND_CLOSE;
                        rec.length   = len_acc_reg;
                        rec.reason   = (close_cnt_next == 2'd2) ? reason_next : 16'd0;
                        rec.last     = 1'b1;
                        phase_next   = PH_LEAD;
                    end
                end
                default:
                begin
                    // lead byte: FIN, reserve bits, opcode
                    fault_valid_next = |data_byte[6:4];
                    fault_code_next  = wsfr_pkg::ERR_RSV;
                    opcode_next      = data_byte[3:0];
                    fin_next         = data_byte[7];
                    phase_next       = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            opcode_reg      <= '0;
            fin_reg         <= 1'b0;
            len_acc_reg     <= '0;
            ext_left_reg    <= '0;
            key_reg         <= '0;
            idx_reg         <= '0;
            remain_reg      <= '0;
            reason_reg      <= '0;
            close_cnt_reg   <= '0;
            halted_reg      <= 1'b0;
            fault_valid_reg <= 1'b0;
            fault_code_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            opcode_reg      <= opcode_next;
            fin_reg         <= fin_next;
            len_acc_reg     <= len_acc_next;
            ext_left_reg    <= ext_left_next;
            key_reg         <= key_next;
            idx_reg         <= idx_next;
            remain_reg      <= remain_next;
            reason_reg      <= reason_next;
            close_cnt_reg   <= close_cnt_next;
            halted_reg      <= halted_next;
            fault_valid_reg <= fault_valid_next;
            fault_code_reg  <= fault_code_next;
        end
    end

`ifndef SYNTHESIS
    a_rec_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> accept)
        else $error("record without an accepted item");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == wsfr_pkg::CMD_RESTART) |=> (phase_reg == PH_LEAD && !halted_reg))
        else $error("restart did not return parser to lead byte");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec.rec_type == wsfr_pkg::REC_ERROR) |=> halted_reg)
        else $error("error record did not halt parser");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !rec_valid)
        else $error("record emitted while halted");
`endif

endmodule

FILE: sv/wsfr_queue.sv
// Back end: short record queue that presents the oldest record to the consumer.
`timescale 1ns / 1ps

module wsfr_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wsfr_pkg::rec_t push_rec,
    input  logic           pop,
    output wsfr_pkg::rec_t head_rec,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    wsfr_pkg::rec_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("record pushed into a full queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not follow a push");
`endif

endmodule

FILE: sv/websocket_frame_receiver.sv
// Top level of the client-to-server frame receiver: parser front end and record queue.
`timescale 1ns / 1ps
// A record caused by an accepted byte goes straight into the queue, with no register in the parser between.
// Throughput: one byte per cycle while the queue is not full; full rises only when DEPTH records wait unpopped.
// The last key byte gives the start record, an error record or an empty close's record;
// earlier header bytes give none. Payload bytes give one record each, close payload one at its end.
// Reset (rst_n low, asynchronous) returns the parser to the lead byte and empties the queue.

module websocket_frame_receiver
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    // item input
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  data_byte,

    // record output
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  record_type,
    output logic [2:0]  frame_kind,
    output logic [63:0] frame_length,
    output logic [7:0]  payload_byte,
    output logic [15:0] close_reason,
    output logic [2:0]  error_code,
    output logic        last
);

    // An item is taken whenever the queue has room; each item yields at most one
    // record, so a free slot is all the parser needs to avoid losing one.
    logic           item_accept;
    logic           rec_valid;
    wsfr_pkg::rec_t rec;
    wsfr_pkg::rec_t head_rec;

    assign item_accept = push && !full;

    // Front end: header parsing, fault checks, unmasking and record building
    wsfr_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (item_accept),
        .command   (command),
        .data_byte (data_byte),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // Back end: records wait here until the consumer pops them, so a stalled
    // consumer does not stop the byte stream until the queue fills.
    wsfr_queue
    #(
        .DEPTH (DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_valid),
        .push_rec (rec),
        .pop      (pop),
        .head_rec (head_rec),
        .full     (full),
        .empty    (empty)
    );

    // Record fields to ports; unused fields are already zero in each record
    assign record_type  = head_rec.rec_type;
    assign frame_kind   = head_rec.kind;
    assign frame_length = head_rec.length;
    assign payload_byte = head_rec.data;
    assign close_reason = head_rec.reason;
    assign error_code   = head_rec.err;
    assign last         = head_rec.last;

endmodule
